// File: design/ttt_pkg.sv
// Shared types, constants and register codes for the travel-time threshold block.
package ttt_pkg;

  localparam int SAMPLE_W       = 12;
  localparam int TIME_W         = 32;
  localparam int OFFSET_W       = 16;
  localparam int WINDOW_LEN_DEF = 10;
  localparam int QUEUE_DEPTH    = 4;
  localparam int QCNT_W         = $clog2(QUEUE_DEPTH + 1);
  localparam int CFG_INDEX_W    = 2;
  localparam int CFG_DATA_W     = 32;
  localparam int IN_DATA_W      = 48;
  localparam int OUT_DATA_W     = 56;

  localparam logic [SAMPLE_W-1:0] LOW_THR_RESET  = 12'd0;
  localparam logic [SAMPLE_W-1:0] HIGH_THR_RESET = 12'd4095;
  localparam logic [OFFSET_W-1:0] OFFSET_RESET   = 16'd0;
  localparam logic [TIME_W-1:0]   TIMEOUT_RESET  = 32'd10000;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_LOW_THR  = 2'd0,
    REG_HIGH_THR = 2'd1,
    REG_OFFSET   = 2'd2,
    REG_TIMEOUT  = 2'd3
  } cfg_reg_t;

  typedef enum logic [2:0] {
    MODE_START = 3'd0,
    MODE_LOW   = 3'd1,
    MODE_HIGH  = 3'd2,
    MODE_RISE  = 3'd3,
    MODE_FALL  = 3'd4,
    MODE_ERROR = 3'd5
  } mode_t;

  typedef struct packed {
    logic [SAMPLE_W-1:0] low_thr;
    logic [SAMPLE_W-1:0] high_thr;
    logic [OFFSET_W-1:0] offset;
    logic [TIME_W-1:0]   timeout;
  } cfg_t;

  // Classified request handed from the front end to the sequencer
  typedef struct packed {
    logic [TIME_W-1:0]   now_ms;
    logic                duration_clear;
    logic [SAMPLE_W-1:0] position;
    logic                lt_low;
    logic                gt_low;
    logic                lt_high;
    logic                gt_high;
  } cls_t;

  typedef struct packed {
    logic              empty;
    logic [QCNT_W-1:0] count;
  } q_stat_t;

  typedef struct packed {
    logic                restart_request;
    logic [TIME_W-1:0]   duration_ms;
    logic                timeout_warning;
    logic                measure_ended;
    logic                measure_started;
    logic [SAMPLE_W-1:0] position;
    mode_t               mode;
  } res_t;

endpackage

// File: design/ttt_front.sv
// Front end: sample window, running sum, average and threshold classification.
module ttt_front #(
  parameter int WINDOW_LEN = ttt_pkg::WINDOW_LEN_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic                      has_sample,
  input  logic [ttt_pkg::SAMPLE_W-1:0] sample,
  input  logic [ttt_pkg::TIME_W-1:0]   now_ms,
  input  logic                      duration_clear,
  input  ttt_pkg::cfg_t             cfg,
  input  ttt_pkg::q_stat_t          q_stat,
  output logic                      push,
  output ttt_pkg::cls_t             push_entry
);
  import ttt_pkg::*;

  localparam int SUM_W   = SAMPLE_W + $clog2(WINDOW_LEN);
  localparam int SHIFT   = SUM_W + $clog2(WINDOW_LEN);
  localparam int RECIP_W = SUM_W + 1;
  localparam int PROD_W  = SUM_W + RECIP_W;
  localparam int OCC_W   = $clog2(QUEUE_DEPTH + 3);
  // ceil(2^SHIFT / WINDOW_LEN): exact floor quotient for any SUM_W-bit sum
  localparam longint RECIP_FULL =
    ((longint'(1) << SHIFT) + longint'(WINDOW_LEN) - 1) / longint'(WINDOW_LEN);
  localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(RECIP_FULL);

  logic [SAMPLE_W-1:0] win_r   [WINDOW_LEN];
  logic [SAMPLE_W-1:0] win_nxt [WINDOW_LEN];
  logic [SUM_W-1:0]    sum_r, sum_nxt;
  logic                accept;
  logic [OCC_W-1:0]    occupancy;

  logic                s1_valid_r;
  logic [SUM_W-1:0]    s1_sum_r;
  logic [TIME_W-1:0]   s1_now_r;
  logic                s1_clear_r;

  logic                s2_valid_r;
  logic [SAMPLE_W-1:0] s2_pos_r;
  logic [TIME_W-1:0]   s2_now_r;
  logic                s2_clear_r;

  logic [PROD_W-1:0]   prod;

  // Accept only while the queue can absorb everything already in flight
  assign occupancy = OCC_W'(q_stat.count) + OCC_W'(s1_valid_r) + OCC_W'(s2_valid_r);
  assign in_ready  = occupancy < OCC_W'(QUEUE_DEPTH);
  assign accept    = in_valid & in_ready;

  always_comb begin
    win_nxt = win_r;
    sum_nxt = sum_r;
    if (accept && has_sample) begin
      win_nxt[0] = sample;
      for (int i = 1; i < WINDOW_LEN; i++) begin
        win_nxt[i] = win_r[i-1];
      end
      sum_nxt = sum_r + SUM_W'(sample) - SUM_W'(win_r[WINDOW_LEN-1]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < WINDOW_LEN; i++) begin
        win_r[i] <= '0;
      end
      sum_r      <= '0;
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
    end else begin
      win_r      <= win_nxt;
      sum_r      <= sum_nxt;
      s1_valid_r <= accept;
      s2_valid_r <= s1_valid_r;
    end
  end

  assign prod = PROD_W'(s1_sum_r) * PROD_W'(RECIP);

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_sum_r   <= sum_nxt;
      s1_now_r   <= now_ms;
      s1_clear_r <= duration_clear;
    end
    if (s1_valid_r) begin
      s2_pos_r   <= SAMPLE_W'(prod >> SHIFT);
      s2_now_r   <= s1_now_r;
      s2_clear_r <= s1_clear_r;
    end
  end

  assign push = s2_valid_r;

  always_comb begin
    push_entry.now_ms         = s2_now_r;
    push_entry.duration_clear = s2_clear_r;
    push_entry.position       = s2_pos_r;
    push_entry.lt_low         = s2_pos_r < cfg.low_thr;
    push_entry.gt_low         = s2_pos_r > cfg.low_thr;
    push_entry.lt_high        = s2_pos_r < cfg.high_thr;
    push_entry.gt_high        = s2_pos_r > cfg.high_thr;
  end

endmodule

// File: design/ttt_queue.sv
// Short request queue between the front end and the sequencer.
module ttt_queue (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  ttt_pkg::cls_t    push_entry,
  input  logic             pop,
  output ttt_pkg::cls_t    head,
  output ttt_pkg::q_stat_t stat
);
  import ttt_pkg::*;

  localparam int PTR_W = $clog2(QUEUE_DEPTH);

  cls_t              mem_r [QUEUE_DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r, rd_ptr_r;
  logic [QCNT_W-1:0] count_r;

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + PTR_W'(1);
      end
      if (push && !pop) begin
        count_r <= count_r + QCNT_W'(1);
      end else if (pop && !push) begin
        count_r <= count_r - QCNT_W'(1);
      end
    end
  end

  assign head       = mem_r[rd_ptr_r];
  assign stat.empty = count_r == '0;
  assign stat.count = count_r;

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> (count_r < QCNT_W'(QUEUE_DEPTH)) || pop)
    else $error("request queue overflow");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> count_r != '0)
    else $error("request queue underflow");

endmodule

// File: design/ttt_back.sv
// Sequencer: position state machine, travel timing and result register.
module ttt_back (
  input  logic             clk,
  input  logic             rst_n,
  input  ttt_pkg::cls_t    head,
  input  ttt_pkg::q_stat_t q_stat,
  input  ttt_pkg::cfg_t    cfg,
  output logic             pop,
  output logic             out_valid,
  input  logic             out_ready,
  output ttt_pkg::res_t    res
);
  import ttt_pkg::*;

  mode_t               mode_r, mode_nxt;
  logic [TIME_W-1:0]   mark_r, mark_nxt;
  logic [TIME_W-1:0]   start_time_r, start_time_nxt;
  logic                start_set_r, start_set_nxt;
  logic [TIME_W-1:0]   dlat_r, dlat_nxt;
  logic                out_valid_r;
  res_t                res_r;

  logic [TIME_W-1:0]   dlat_in, st_base, elapsed, travel;
  logic                start_over, trav_over, idle, far;
  logic                started, ended, warn, restart;

  assign pop = !q_stat.empty && (!out_valid_r || out_ready);

  assign dlat_in    = head.duration_clear ? '0 : dlat_r;
  assign st_base    = start_set_r ? start_time_r : head.now_ms;
  assign start_over = (head.now_ms - st_base) > cfg.timeout;
  assign elapsed    = head.now_ms - mark_r;
  assign travel     = elapsed + TIME_W'({cfg.offset, 1'b0});
  assign trav_over  = elapsed > cfg.timeout;
  assign idle       = dlat_in == '0;
  assign far        = (mode_r == MODE_RISE) ? head.gt_high : head.lt_low;

  // Next state
  always_comb begin
    mode_nxt = mode_r;
    case (mode_r)
      MODE_START: begin
        if (start_over) begin
          mode_nxt = MODE_START;
        end else if (head.lt_low) begin
          mode_nxt = MODE_LOW;
        end else if (head.gt_high) begin
          mode_nxt = MODE_HIGH;
        end
      end
      MODE_LOW: begin
        if (head.gt_low && idle) begin
          mode_nxt = MODE_RISE;
        end
      end
      MODE_HIGH: begin
        if (head.lt_high && idle) begin
          mode_nxt = MODE_FALL;
        end
      end
      MODE_RISE, MODE_FALL: begin
        if (far) begin
          mode_nxt = (mode_r == MODE_RISE) ? MODE_HIGH : MODE_LOW;
        end else if (trav_over) begin
          mode_nxt = MODE_ERROR;
        end
      end
      default: begin
        if (head.lt_low) begin
          mode_nxt = MODE_LOW;
        end else if (head.gt_high) begin
          mode_nxt = MODE_HIGH;
        end else begin
          mode_nxt = MODE_ERROR;
        end
      end
    endcase
  end

  // Flags and timing registers
  always_comb begin
    started        = 1'b0;
    ended          = 1'b0;
    warn           = 1'b0;
    restart        = 1'b0;
    mark_nxt       = mark_r;
    start_time_nxt = start_time_r;
    start_set_nxt  = start_set_r;
    dlat_nxt       = dlat_in;
    case (mode_r)
      MODE_START: begin
        start_time_nxt = st_base;
        start_set_nxt  = 1'b1;
        if (start_over) begin
          restart = 1'b1;
        end else if (head.lt_low || head.gt_high) begin
          start_set_nxt = 1'b0;
        end
      end
      MODE_LOW: begin
        if (head.gt_low && idle) begin
          dlat_nxt = TIME_W'(1);
          mark_nxt = head.now_ms;
          started  = 1'b1;
        end
      end
      MODE_HIGH: begin
        if (head.lt_high && idle) begin
          dlat_nxt = TIME_W'(1);
          mark_nxt = head.now_ms;
          started  = 1'b1;
        end
      end
      MODE_RISE, MODE_FALL: begin
        if (far || trav_over) begin
          dlat_nxt = travel;
          mark_nxt = '0;
          ended    = 1'b1;
          warn     = !far;
        end
      end
      default: begin
        started = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r       <= MODE_START;
      mark_r       <= '0;
      start_time_r <= '0;
      start_set_r  <= 1'b0;
      dlat_r       <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      if (pop) begin
        mode_r       <= mode_nxt;
        mark_r       <= mark_nxt;
        start_time_r <= start_time_nxt;
        start_set_r  <= start_set_nxt;
        dlat_r       <= dlat_nxt;
        out_valid_r  <= 1'b1;
      end else if (out_ready) begin
        out_valid_r  <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      res_r.mode            <= mode_nxt;
      res_r.position        <= head.position;
      res_r.measure_started <= started;
      res_r.measure_ended   <= ended;
      res_r.timeout_warning <= warn;
      res_r.duration_ms     <= dlat_nxt;
      res_r.restart_request <= restart;
    end
  end

  assign out_valid = out_valid_r;
  assign res       = res_r;

  a_warn_means_error: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && res_r.timeout_warning |->
      res_r.measure_ended && res_r.mode == MODE_ERROR)
    else $error("timeout warning without an ended measurement in error");

  a_start_marks_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && res_r.measure_started |->
      res_r.duration_ms == TIME_W'(1) &&
      (res_r.mode == MODE_RISE || res_r.mode == MODE_FALL))
    else $error("measurement start without busy latch or travel state");

endmodule

// File: design/travel_time_threshold_fsm_top.sv
// Top level of the travel-time threshold block: ports, registers and assembly.
//
// Each request may shift a new 12-bit position sample into a moving-average
// window, and carries the current millisecond time and a flag that clears the
// duration latch. The average drives a six-state position machine (start, low,
// high, rising, falling, error) that times travel between the two thresholds
// and reports one result per request. The block takes one request per clock
// cycle sustained while the output side takes each result. A request passes a
// running-sum stage, a stage holding the constant-reciprocal multiply that forms
// the average (exact floor of sum over the window length) and threshold compare,
// a four-entry queue, and the state machine, which writes the output register.
// The queue lets the output side stall on its own: in_tready drops only when the
// queue plus the two front stages would fill it, and returns after the state
// machine pops a queue entry. Registers are written over the cfg_ port (always
// ready); the user must write them only while no request is in flight, which the
// block itself does not enforce. Index 0 is the low threshold, 1 high threshold,
// 2 time offset in ms (added twice to each duration), 3 timeout in ms.
module travel_time_threshold_fsm_top #(
  parameter int WINDOW_LEN = ttt_pkg::WINDOW_LEN_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // [11:0] sample, [43:12] now_ms, [44] duration_clear, rest zero
  input  logic [ttt_pkg::IN_DATA_W-1:0]    in_tdata,
  // [0] has_sample
  input  logic                             in_tuser,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // [2:0] mode, [14:3] position, [15] measure_started, [16] measure_ended,
  // [17] timeout_warning, [49:18] duration_ms, [50] restart_request, rest zero
  output logic [ttt_pkg::OUT_DATA_W-1:0]   out_tdata,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [ttt_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [ttt_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import ttt_pkg::*;

  cfg_t    cfg_r;
  q_stat_t q_stat;
  cls_t    push_entry, head;
  res_t    res;
  logic    push, pop;

  // Register writes are always taken
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.low_thr  <= LOW_THR_RESET;
      cfg_r.high_thr <= HIGH_THR_RESET;
      cfg_r.offset   <= OFFSET_RESET;
      cfg_r.timeout  <= TIMEOUT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_reg_t'(cfg_index))
        REG_LOW_THR:  cfg_r.low_thr  <= cfg_data[SAMPLE_W-1:0];
        REG_HIGH_THR: cfg_r.high_thr <= cfg_data[SAMPLE_W-1:0];
        REG_OFFSET:   cfg_r.offset   <= cfg_data[OFFSET_W-1:0];
        REG_TIMEOUT:  cfg_r.timeout  <= cfg_data[TIME_W-1:0];
        default: begin
          cfg_r <= cfg_r;
        end
      endcase
    end
  end

  // Window, average and classification
  ttt_front #(
    .WINDOW_LEN (WINDOW_LEN)
  ) u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_tvalid),
    .in_ready       (in_tready),
    .has_sample     (in_tuser),
    .sample         (in_tdata[11:0]),
    .now_ms         (in_tdata[43:12]),
    .duration_clear (in_tdata[44]),
    .cfg            (cfg_r),
    .q_stat         (q_stat),
    .push           (push),
    .push_entry     (push_entry)
  );

  // Decouple classification from the state machine
  ttt_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .head       (head),
    .stat       (q_stat)
  );

  // Position state machine and output register
  ttt_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head      (head),
    .q_stat    (q_stat),
    .cfg       (cfg_r),
    .pop       (pop),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .res       (res)
  );

  // Pack the result, lowest field first
  assign out_tdata = {5'b0, res.restart_request, res.duration_ms, res.timeout_warning,
                      res.measure_ended, res.measure_started, res.position, res.mode};

endmodule
